// ===== hw/rtl/tbp_pkg.sv =====
// Shared types and constants for the tournament branch predictor.
package tbp_pkg;

    localparam int BIMODAL_ENTRIES = 4096;
    localparam int GSHARE_ENTRIES  = 4096;
    localparam int CHOICE_ENTRIES  = 4096;
    localparam int TARGET_SETS     = 256;
    localparam int TARGET_WAYS     = 4;
    localparam int RETURN_DEPTH    = 256;

    localparam int BW = $clog2(BIMODAL_ENTRIES);
    localparam int GW = $clog2(GSHARE_ENTRIES);
    localparam int CW = $clog2(CHOICE_ENTRIES);
    localparam int SW = (TARGET_SETS > 1) ? $clog2(TARGET_SETS) : 1;
    localparam int WW = (TARGET_WAYS > 1) ? $clog2(TARGET_WAYS) : 1;
    localparam int RW = $clog2(RETURN_DEPTH);
    localparam int AGE_W = WW;

    localparam logic [1:0] MODE_PERFECT  = 2'd0;
    localparam logic [1:0] MODE_TAKEN    = 2'd1;
    localparam logic [1:0] MODE_NOTTAKEN = 2'd2;
    localparam logic [1:0] MODE_COMBINED = 2'd3;

    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_BRANCH = 2'd1;
    localparam logic [1:0] CLS_CALL   = 2'd2;
    localparam logic [1:0] CLS_RETURN = 2'd3;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [1:0] CTR_INIT = 2'd2;

    // one target buffer set row: tags, addresses, ages for all ways
    localparam int ROW_W = TARGET_WAYS * (32 + 32 + AGE_W);

    typedef struct packed {
        logic        func;
        logic [31:0] pc;
        logic [3:0]  length;
        logic [1:0]  branch_class;
        logic        speculative;
        logic [31:0] actual_next;
        logic [31:0] guessed_next;
        logic [11:0] gshare_slot_in;
        logic        bimodal_guess_in;
        logic        gshare_guess_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_address;
        logic [11:0] gshare_slot;
        logic        bimodal_guess;
        logic        gshare_guess;
        logic [31:0] access_total;
        logic [31:0] hit_total;
    } out_item_t;

    function automatic logic [1:0] train(input logic [1:0] c, input logic up);
        logic [1:0] r;
        begin
            if (up)
                r = (c == 2'd3) ? 2'd3 : c + 2'd1;
            else
                r = (c == 2'd0) ? 2'd0 : c - 2'd1;
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/tbp_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tbp_btb_logic.sv =====
// Target buffer set logic: hit search for lookup and LRU update of one set row.
module tbp_btb_logic
    import tbp_pkg::*;
(
    input  logic [ROW_W-1:0] row,
    input  logic [31:0]      pc,
    input  logic [31:0]      fall,
    input  logic [31:0]      dest,
    output logic [31:0]      target,
    output logic [ROW_W-1:0] row_upd
);

    logic [31:0]      tags  [TARGET_WAYS];
    logic [31:0]      addrs [TARGET_WAYS];
    logic [AGE_W-1:0] ages  [TARGET_WAYS];
    logic [31:0]      lk_addr;
    logic             up_hit;
    logic [AGE_W-1:0] ref_age;
    logic [WW-1:0]    up_way;

    always_comb
    begin
        for (int w = 0; w < TARGET_WAYS; w++)
        begin
            tags[w]  = row[w*(64+AGE_W) +: 32];
            addrs[w] = row[w*(64+AGE_W)+32 +: 32];
            ages[w]  = row[w*(64+AGE_W)+64 +: AGE_W];
        end
        // lowest matching way for lookup
        lk_addr = fall;
        for (int w = TARGET_WAYS - 1; w >= 0; w--)
            if (tags[w] == pc)
                lk_addr = addrs[w];
        target = lk_addr;
        // highest matching way for update
        up_hit = 1'b0;
        up_way = '0;
        for (int w = 0; w < TARGET_WAYS; w++)
            if (tags[w] == pc)
            begin
                up_hit = 1'b1;
                up_way = WW'(w);
            end
        ref_age = ages[up_way];
        row_upd = row;
        for (int w = 0; w < TARGET_WAYS; w++)
        begin
            if (!up_hit)
            begin
                if (ages[w] == '0)
                begin
                    row_upd[w*(64+AGE_W) +: 32]        = pc;
                    row_upd[w*(64+AGE_W)+32 +: 32]     = dest;
                    row_upd[w*(64+AGE_W)+64 +: AGE_W]  = AGE_W'(TARGET_WAYS - 1);
                end
                else
                    row_upd[w*(64+AGE_W)+64 +: AGE_W]  = ages[w] - AGE_W'(1);
            end
            else if (WW'(w) == up_way)
                row_upd[w*(64+AGE_W)+64 +: AGE_W] = AGE_W'(TARGET_WAYS - 1);
            else if (ages[w] > ref_age)
                row_upd[w*(64+AGE_W)+64 +: AGE_W] = ages[w] - AGE_W'(1);
        end
    end

endmodule

// ===== hw/rtl/tournament_branch_predictor_btb_ras_core.sv =====
// Top level: tournament branch predictor with target buffer and return stack.
// Each beat steps through presenting the table addresses, the synchronous memory
// reads, and computing, writing back and registering the result.
// The next beat is taken in the cycle the previous result leaves; a stalled
// result holds off the input.
// After reset a clearing pass restores every table before the first beat is taken.
// Configuration writes are accepted only while no beat is being processed.
module tournament_branch_predictor_btb_ras_core
    import tbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int CLR_N = (BIMODAL_ENTRIES > GSHARE_ENTRIES ?
        (BIMODAL_ENTRIES > CHOICE_ENTRIES ? BIMODAL_ENTRIES : CHOICE_ENTRIES) :
        (GSHARE_ENTRIES > CHOICE_ENTRIES ? GSHARE_ENTRIES : CHOICE_ENTRIES));
    localparam int CLR_M = (CLR_N > TARGET_SETS ? CLR_N : TARGET_SETS) > RETURN_DEPTH ?
        (CLR_N > TARGET_SETS ? CLR_N : TARGET_SETS) : RETURN_DEPTH;
    localparam int CLW = $clog2(CLR_M) + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [CLW-1:0] clr_reg;
    logic [1:0]     mode_reg;
    in_item_t       item_reg;
    logic [RW-1:0]  rp_reg;
    logic [GW-1:0]  ghist_reg;
    logic [31:0]    acc_reg, hit_reg;
    logic           ovalid_reg;
    out_item_t      odata_reg;

    assign cfg_ready = state_reg == ST_CLEAR || state_reg == ST_IDLE;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_COMBINED;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // derived item values
    logic [31:0] fall;
    logic        is_look, use_ras_pop, use_ras_push, is_direct;
    logic [RW-1:0] rp_dec;
    logic [GW-1:0] gslot_look;
    assign fall        = item_reg.pc + {28'd0, item_reg.length};
    assign is_look     = item_reg.func == FUNC_LOOKUP;
    assign is_direct   = item_reg.branch_class == CLS_NONE || mode_reg == MODE_PERFECT;
    assign use_ras_pop = is_look && !is_direct && !item_reg.speculative
                         && item_reg.branch_class == CLS_RETURN;
    assign use_ras_push = is_look && !is_direct && !item_reg.speculative
                         && item_reg.branch_class == CLS_CALL;
    assign rp_dec      = rp_reg - RW'(1);
    assign gslot_look  = item_reg.pc[GW-1:0] ^ ghist_reg;

    // memories
    logic             clearing, wb;
    logic [BW-1:0]    bim_ra, bim_wa; logic [1:0] bim_rd, bim_wd; logic bim_we;
    logic [GW-1:0]    gsh_ra, gsh_wa; logic [1:0] gsh_rd, gsh_wd; logic gsh_we;
    logic [CW-1:0]    cho_ra, cho_wa; logic [1:0] cho_rd, cho_wd; logic cho_we;
    logic [SW-1:0]    btb_a, btb_wa; logic [ROW_W-1:0] btb_rd, btb_wd, row_upd;
    logic             btb_we;
    logic [RW-1:0]    ras_ra, ras_wa; logic [31:0] ras_rd, ras_wd; logic ras_we;
    logic [ROW_W-1:0] row_init;
    logic [31:0]      target;
    logic             taken_upd, train_comb;

    assign clearing = state_reg == ST_CLEAR;
    assign wb       = state_reg == ST_EXEC;

    always_comb
    begin
        row_init = '0;
        for (int w = 0; w < TARGET_WAYS; w++)
            row_init[w*(64+AGE_W)+64 +: AGE_W] = AGE_W'(w);
    end

    assign bim_ra = item_reg.pc[BW-1:0];
    assign cho_ra = item_reg.pc[CW-1:0];
    assign gsh_ra = is_look ? gslot_look : item_reg.gshare_slot_in[GW-1:0];
    assign btb_a  = (TARGET_SETS > 1) ? item_reg.pc[SW-1:0] : '0;
    assign ras_ra = rp_dec;

    assign taken_upd  = item_reg.actual_next != fall;
    assign train_comb = !is_look && mode_reg == MODE_COMBINED
                        && item_reg.branch_class != CLS_CALL
                        && item_reg.branch_class != CLS_RETURN;

    assign bim_we = clearing ? (clr_reg < CLW'(BIMODAL_ENTRIES)) : (wb && train_comb);
    assign bim_wa = clearing ? clr_reg[BW-1:0] : bim_ra;
    assign bim_wd = clearing ? CTR_INIT : train(bim_rd, taken_upd);
    assign gsh_we = clearing ? (clr_reg < CLW'(GSHARE_ENTRIES)) : (wb && train_comb);
    assign gsh_wa = clearing ? clr_reg[GW-1:0] : gsh_ra;
    assign gsh_wd = clearing ? CTR_INIT : train(gsh_rd, taken_upd);
    assign cho_we = clearing ? (clr_reg < CLW'(CHOICE_ENTRIES))
                    : (wb && train_comb && item_reg.bimodal_guess_in != item_reg.gshare_guess_in);
    assign cho_wa = clearing ? clr_reg[CW-1:0] : cho_ra;
    assign cho_wd = clearing ? CTR_INIT
                    : train(cho_rd, item_reg.bimodal_guess_in != taken_upd);
    assign btb_we = clearing ? (clr_reg < CLW'(TARGET_SETS))
                    : (wb && !is_look && item_reg.branch_class != CLS_RETURN);
    assign btb_wa = clearing ? clr_reg[SW-1:0] : btb_a;
    assign btb_wd = clearing ? row_init : row_upd;
    assign ras_we = clearing ? (clr_reg < CLW'(RETURN_DEPTH)) : (wb && use_ras_push);
    assign ras_wa = clearing ? clr_reg[RW-1:0] : rp_reg;
    assign ras_wd = clearing ? 32'd0 : fall;

    tbp_ram #(.WIDTH(2), .DEPTH(BIMODAL_ENTRIES)) u_bim (.clk(clk), .we(bim_we),
        .waddr(bim_wa), .wdata(bim_wd), .raddr(bim_ra), .rdata(bim_rd));
    tbp_ram #(.WIDTH(2), .DEPTH(GSHARE_ENTRIES)) u_gsh (.clk(clk), .we(gsh_we),
        .waddr(gsh_wa), .wdata(gsh_wd), .raddr(gsh_ra), .rdata(gsh_rd));
    tbp_ram #(.WIDTH(2), .DEPTH(CHOICE_ENTRIES)) u_cho (.clk(clk), .we(cho_we),
        .waddr(cho_wa), .wdata(cho_wd), .raddr(cho_ra), .rdata(cho_rd));
    tbp_ram #(.WIDTH(ROW_W), .DEPTH(TARGET_SETS)) u_btb (.clk(clk), .we(btb_we),
        .waddr(btb_wa), .wdata(btb_wd), .raddr(btb_a), .rdata(btb_rd));
    tbp_ram #(.WIDTH(32), .DEPTH(RETURN_DEPTH)) u_ras (.clk(clk), .we(ras_we),
        .waddr(ras_wa), .wdata(ras_wd), .raddr(ras_ra), .rdata(ras_rd));

    tbp_btb_logic u_btbl (
        .row(btb_rd), .pc(item_reg.pc), .fall(fall), .dest(item_reg.actual_next),
        .target(target), .row_upd(row_upd)
    );

    // result for the item in execute
    logic      bim_t, gsh_t, take;
    out_item_t res;
    logic [31:0] acc_n, hit_n;
    assign bim_t = bim_rd > 2'd1;
    assign gsh_t = gsh_rd > 2'd1;
    assign take  = (cho_rd < 2'd2) ? bim_t : gsh_t;
    assign acc_n = is_look ? acc_reg : acc_reg + 32'd1;
    assign hit_n = (!is_look && item_reg.actual_next == item_reg.guessed_next)
                   ? hit_reg + 32'd1 : hit_reg;

    always_comb
    begin
        res = '0;
        res.access_total = acc_n;
        res.hit_total    = hit_n;
        if (is_look)
        begin
            if (is_direct)
                res.next_address = item_reg.actual_next;
            else if (use_ras_pop)
                res.next_address = ras_rd;
            else
            begin
                case (mode_reg)
                    MODE_NOTTAKEN: res.next_address = fall;
                    MODE_TAKEN:    res.next_address = target;
                    default:
                    begin
                        res.next_address  = take ? target : fall;
                        res.gshare_slot   = 12'(gslot_look);
                        res.bimodal_guess = bim_t;
                        res.gshare_guess  = gsh_t;
                    end
                endcase
            end
        end
    end

    logic comb_look;
    assign comb_look = is_look && !is_direct && !use_ras_pop && mode_reg == MODE_COMBINED;

    // input may be taken in the cycle the waiting result beat leaves
    logic out_free;
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CLW'(CLR_M - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid && out_free) state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign in_stall = !(state_reg == ST_IDLE && out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            rp_reg     <= '0;
            ghist_reg  <= '0;
            acc_reg    <= '0;
            hit_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + CLW'(1);
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (wb)
            begin
                ovalid_reg <= 1'b1;
                acc_reg    <= acc_n;
                hit_reg    <= hit_n;
                if (use_ras_pop)
                    rp_reg <= rp_dec;
                else if (use_ras_push)
                    rp_reg <= rp_reg + RW'(1);
                if (comb_look)
                    ghist_reg <= {ghist_reg[GW-2:0], gsh_t};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
        if (wb)
            odata_reg <= res;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// ===== test/tournament_branch_predictor_btb_ras_core_tb.sv =====
// Self-checking testbench for the tournament branch predictor core.
module tournament_branch_predictor_btb_ras_core_tb;
    import tbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_data;

    tournament_branch_predictor_btb_ras_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    localparam int TGT_TOTAL = TARGET_SETS * TARGET_WAYS;

    // predictor shadow state
    logic [1:0]  mode_q;
    logic [31:0] ras_mem [RETURN_DEPTH];
    logic [RW-1:0] ras_ptr;
    logic [31:0] btb_tag [TGT_TOTAL];
    logic [31:0] btb_dst [TGT_TOTAL];
    int          btb_age [TGT_TOTAL];
    logic [1:0]  bim_ctr [BIMODAL_ENTRIES];
    logic [1:0]  gsh_ctr [GSHARE_ENTRIES];
    logic [1:0]  sel_ctr [CHOICE_ENTRIES];
    logic [GW-1:0] ghist;
    logic [31:0] n_access;
    logic [31:0] n_hits;

    in_item_t  pending_items[$];
    out_item_t expected_preds[$];
    bit        quiet;
    int        n_errors;
    logic [31:0] recent_pc[$];

    always #1 clk = ~clk;

    function automatic logic [1:0] sat_step(logic [1:0] c, bit up);
        if (up)
            return (c == 2'd3) ? 2'd3 : c + 2'd1;
        return (c == 2'd0) ? 2'd0 : c - 2'd1;
    endfunction

    function automatic logic [31:0] btb_find(logic [31:0] pc, logic [31:0] fall);
        int base;
        base = int'(pc[SW-1:0]) * TARGET_WAYS;
        for (int w = 0; w < TARGET_WAYS; w++)
            if (btb_tag[base + w] == pc)
                return btb_dst[base + w];
        return fall;
    endfunction

    task automatic btb_train(logic [31:0] pc, logic [31:0] dst);
        int base;
        int hit_way;
        int ref_age;
        base = int'(pc[SW-1:0]) * TARGET_WAYS;
        hit_way = -1;
        for (int w = 0; w < TARGET_WAYS; w++)
            if (btb_tag[base + w] == pc)
                hit_way = w;
        if (hit_way < 0) begin
            for (int w = 0; w < TARGET_WAYS; w++) begin
                if (btb_age[base + w] == 0) begin
                    btb_age[base + w] = TARGET_WAYS - 1;
                    btb_tag[base + w] = pc;
                    btb_dst[base + w] = dst;
                end
                else
                    btb_age[base + w]--;
            end
        end
        else begin
            ref_age = btb_age[base + hit_way];
            for (int w = 0; w < TARGET_WAYS; w++)
                if (btb_age[base + w] > ref_age)
                    btb_age[base + w]--;
            btb_age[base + hit_way] = TARGET_WAYS - 1;
        end
    endtask

    task automatic predict_beat(in_item_t it);
        out_item_t r;
        logic [31:0] fall;
        bit take;
        bit taken;
        logic [GW-1:0] gi;
        r = '0;
        fall = it.pc + 32'(it.length);
        if (it.func == FUNC_LOOKUP) begin
            if (it.branch_class == CLS_NONE || mode_q == MODE_PERFECT)
                r.next_address = it.actual_next;
            else if (!it.speculative && it.branch_class == CLS_RETURN) begin
                ras_ptr = ras_ptr - 1'b1;
                r.next_address = ras_mem[ras_ptr];
            end
            else begin
                if (!it.speculative && it.branch_class == CLS_CALL) begin
                    ras_mem[ras_ptr] = fall;
                    ras_ptr = ras_ptr + 1'b1;
                end
                if (mode_q == MODE_NOTTAKEN)
                    r.next_address = fall;
                else if (mode_q == MODE_TAKEN)
                    r.next_address = btb_find(it.pc, fall);
                else begin
                    r.bimodal_guess = bim_ctr[it.pc[BW-1:0]] > 2'd1;
                    gi = it.pc[GW-1:0] ^ ghist;
                    r.gshare_slot = 12'(gi);
                    r.gshare_guess = gsh_ctr[gi] > 2'd1;
                    ghist = {ghist[GW-2:0], r.gshare_guess};
                    take = (sel_ctr[it.pc[CW-1:0]] < 2'd2) ? r.bimodal_guess
                                                          : r.gshare_guess;
                    r.next_address = take ? btb_find(it.pc, fall) : fall;
                end
            end
        end
        else begin
            if (it.branch_class != CLS_RETURN)
                btb_train(it.pc, it.actual_next);
            if (mode_q == MODE_COMBINED && it.branch_class != CLS_CALL
                    && it.branch_class != CLS_RETURN) begin
                taken = it.actual_next != fall;
                bim_ctr[it.pc[BW-1:0]] = sat_step(bim_ctr[it.pc[BW-1:0]], taken);
                gi = it.gshare_slot_in[GW-1:0];
                gsh_ctr[gi] = sat_step(gsh_ctr[gi], taken);
                if (it.bimodal_guess_in != it.gshare_guess_in)
                    sel_ctr[it.pc[CW-1:0]] = sat_step(sel_ctr[it.pc[CW-1:0]],
                                                      it.bimodal_guess_in != taken);
            end
            n_access++;
            if (it.actual_next == it.guessed_next)
                n_hits++;
        end
        r.access_total = n_access;
        r.hit_total = n_hits;
        expected_preds.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall) begin
            if (in_valid)
                predict_beat(in_data);
            if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if (out_valid && !out_stall) begin
                if (expected_preds.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end
                else begin
                    out_item_t e;
                    e = expected_preds.pop_front();
                    if (out_data.next_address !== e.next_address) begin
                        $error("next_address exp %h got %h", e.next_address,
                               out_data.next_address);
                        n_errors++;
                    end
                    if (out_data.gshare_slot !== e.gshare_slot) begin
                        $error("gshare_slot exp %h got %h", e.gshare_slot,
                               out_data.gshare_slot);
                        n_errors++;
                    end
                    if (out_data.bimodal_guess !== e.bimodal_guess) begin
                        $error("bimodal_guess exp %b got %b", e.bimodal_guess,
                               out_data.bimodal_guess);
                        n_errors++;
                    end
                    if (out_data.gshare_guess !== e.gshare_guess) begin
                        $error("gshare_guess exp %b got %b", e.gshare_guess,
                               out_data.gshare_guess);
                        n_errors++;
                    end
                    if (out_data.access_total !== e.access_total) begin
                        $error("access_total exp %h got %h", e.access_total,
                               out_data.access_total);
                        n_errors++;
                    end
                    if (out_data.hit_total !== e.hit_total) begin
                        $error("hit_total exp %h got %h", e.hit_total,
                               out_data.hit_total);
                        n_errors++;
                    end
                end
            end
            out_stall <= !quiet && $urandom_range(99) < 18;
        end
    end

    function automatic in_item_t rand_beat();
        in_item_t it;
        it = '0;
        it.func = 1'($urandom_range(1));
        // mostly reuse a small pool of addresses so the tables train
        if (recent_pc.size() > 0 && $urandom_range(99) < 70)
            it.pc = recent_pc[$urandom_range(recent_pc.size() - 1)];
        else begin
            it.pc = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(4095));
            recent_pc.push_back(it.pc);
            if (recent_pc.size() > 40)
                void'(recent_pc.pop_front());
        end
        it.length = 4'($urandom_range(15, 1));
        it.branch_class = 2'($urandom_range(3));
        it.speculative = ($urandom_range(3) == 0);
        it.actual_next = $urandom_range(1) ? it.pc + 32'(it.length) : $urandom();
        it.guessed_next = $urandom_range(1) ? it.actual_next : $urandom();
        it.gshare_slot_in = $urandom_range(1) ? it.pc[11:0] : 12'($urandom_range(4095));
        it.bimodal_guess_in = 1'($urandom_range(1));
        it.gshare_guess_in = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t mk(logic f, logic [31:0] pc, logic [3:0] len,
                                    logic [1:0] cls, logic sp, logic [31:0] act);
        in_item_t it;
        it = '0;
        it.func = f;
        it.pc = pc;
        it.length = len;
        it.branch_class = cls;
        it.speculative = sp;
        it.actual_next = act;
        it.guessed_next = act;
        it.gshare_slot_in = pc[11:0];
        it.bimodal_guess_in = 1'b1;
        return it;
    endfunction

    task automatic drain_and_configure(logic [1:0] m);
        wait (pending_items.size() == 0 && !in_valid && expected_preds.size() == 0);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_q = m;
    endtask

    initial begin
        logic [1:0] modes[5];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        n_errors = 0;
        mode_q = MODE_COMBINED;
        ras_ptr = '0;
        ghist = '0;
        n_access = '0;
        n_hits = '0;
        for (int i = 0; i < RETURN_DEPTH; i++)
            ras_mem[i] = '0;
        for (int i = 0; i < TGT_TOTAL; i++) begin
            btb_tag[i] = '0;
            btb_dst[i] = '0;
            btb_age[i] = i % TARGET_WAYS;
        end
        for (int i = 0; i < BIMODAL_ENTRIES; i++)
            bim_ctr[i] = CTR_INIT;
        for (int i = 0; i < GSHARE_ENTRIES; i++)
            gsh_ctr[i] = CTR_INIT;
        for (int i = 0; i < CHOICE_ENTRIES; i++)
            sel_ctr[i] = CTR_INIT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset mode is combined
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h0, 4'd1, CLS_BRANCH, 1'b0, 32'h0));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'hFFFF_FFFF, 4'd15, CLS_NONE, 1'b0,
                                   32'hFFFF_FFFF));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'hFFFF_FFFF, 4'd15, CLS_CALL, 1'b0, 32'h5));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h100, 4'd4, CLS_RETURN, 1'b0, 32'h5));
        // underflow wraps to the top of the stack
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h200, 4'd4, CLS_RETURN, 1'b0, 32'h5));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h300, 4'd2, CLS_CALL, 1'b1, 32'h5));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h300, 4'd2, CLS_RETURN, 1'b1, 32'h5));
        pending_items.push_back(mk(FUNC_UPDATE, 32'h400, 4'd4, CLS_BRANCH, 1'b1, 32'h8000));
        pending_items.push_back(mk(FUNC_UPDATE, 32'h400, 4'd4, CLS_NONE, 1'b0, 32'h404));
        pending_items.push_back(mk(FUNC_UPDATE, 32'h500, 4'd4, CLS_RETURN, 1'b0, 32'h9000));
        pending_items.push_back(mk(FUNC_UPDATE, 32'h600, 4'd4, CLS_CALL, 1'b0, 32'hA000));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h400, 4'd4, CLS_BRANCH, 1'b0, 32'h0));
        begin
            in_item_t t;
            t = mk(FUNC_UPDATE, 32'h0, 4'd1, CLS_BRANCH, 1'b0, 32'h1234);
            t.guessed_next = 32'hFFFF_FFFF;
            t.gshare_slot_in = 12'hFFF;
            t.bimodal_guess_in = 1'b0;
            t.gshare_guess_in = 1'b1;
            pending_items.push_back(t);
        end
        // several ways of one set, then eviction
        for (int w = 0; w < 5; w++)
            pending_items.push_back(mk(FUNC_UPDATE, 32'h7 + 32'(w) * 32'h100, 4'd3,
                                       CLS_BRANCH, 1'b0, 32'hC000 + 32'(w)));
        pending_items.push_back(mk(FUNC_LOOKUP, 32'h107, 4'd3, CLS_BRANCH, 1'b0, 32'h0));

        modes[0] = MODE_PERFECT;
        modes[1] = MODE_TAKEN;
        modes[2] = MODE_NOTTAKEN;
        modes[3] = MODE_COMBINED;
        modes[4] = MODE_TAKEN;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0)
                drain_and_configure(modes[ph - 1]);
            quiet = (ph == 4);
            for (int i = 0; i < (ph == 3 ? 530 : 200); i++)
                pending_items.push_back(rand_beat());
        end
        wait (pending_items.size() == 0 && !in_valid && expected_preds.size() == 0);
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
